// ===== hdl/drp_pkg.sv =====
// Shared types, widths, opcodes and constants for the dead-block aware
// replacement unit. No dependencies.
`timescale 1ns / 1ps

package drp_pkg;

    // Field widths of the request, result and configuration ports
    localparam int OP_W       = 2;
    localparam int IDX_W      = 11;
    localparam int WAY_IN_W   = 4;
    localparam int VICT_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_W      = 32;
    localparam int DECAY_W    = 32;
    localparam int LEAD_W     = 11;

    // Opcodes
    localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
    localparam logic [OP_W-1:0] OP_HIT   = 2'd1;
    localparam logic [OP_W-1:0] OP_FILL  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER = 1'd1;

    localparam logic [DECAY_W-1:0] DECAY_RESET  = 32'd100000;
    localparam logic [LEAD_W-1:0]  LEAD_RESET   = 11'd64;

    // Per-line state
    localparam int RRPV_W = 2;
    localparam int DEAD_W = 2;
    localparam int ENT_W  = RRPV_W + DEAD_W;

    localparam logic [RRPV_W-1:0] RRPV_MAX    = 2'd3;
    localparam logic [RRPV_W-1:0] RRPV_MRU    = 2'd0;
    localparam logic [RRPV_W-1:0] RRPV_STATIC = 2'd2;
    localparam logic [RRPV_W-1:0] RRPV_DISTANT = 2'd3;
    localparam logic [DEAD_W-1:0] DEAD_MAX    = 2'd3;
    localparam logic [DEAD_W-1:0] DEAD_ZERO   = 2'd0;
    localparam logic [DEAD_W-1:0] DEAD_FILL   = 2'd1;

    typedef struct packed {
        logic [RRPV_W-1:0] rrpv;
        logic [DEAD_W-1:0] dead;
    } entry_t;

    // rrpv 3, dead counter 0
    localparam logic [ENT_W-1:0] ENTRY_RESET = {RRPV_MAX, DEAD_ZERO};

    // Policy selector
    localparam int SEL_W = 10;
    localparam logic [SEL_W-1:0] SEL_RESET = 10'd512;
    localparam logic [SEL_W-1:0] SEL_MAX   = 10'd1023;
    localparam logic [SEL_W-1:0] SEL_MIN   = 10'd0;

    // Bimodal insertion LFSR (Galois, x^16+x^14+x^13+x^11+1)
    localparam int LFSR_W  = 16;
    localparam int BIP_W   = 5;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'd1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    // Command to the row datapath
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              sweep;
        logic [RRPV_W-1:0] ins_val;
    } row_cmd_t;

    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] r;
        r = s >> 1;
        if (s[0])
        begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

    // Number of compare-subtract steps that reduce a value below max_val+1
    // modulo d. Evaluated at elaboration only.
    function automatic int mod_steps(input int max_val, input int d);
        int n;
        n = 0;
        while ((d << n) <= max_val)
        begin
            n = n + 1;
        end
        return n;
    endfunction

endpackage

// ===== hdl/drp_row_mem.sv =====
// Simple dual-port row memory: one write port, one read port with a
// registered read that holds between reads. No dependencies.
`timescale 1ns / 1ps

module drp_row_mem #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int WIDTH  = 64
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/drp_row_logic.sv =====
// Row datapath: victim search, aging, hit/fill update and decay of one set row.
// Depends on drp_pkg.
`timescale 1ns / 1ps

module drp_row_logic #(
    parameter int WAYS  = 16,
    parameter int WAY_W = 4
) (
    input  drp_pkg::row_cmd_t             cmd,
    input  logic [WAY_W-1:0]              way,
    input  drp_pkg::entry_t [WAYS-1:0]    row_in,
    output drp_pkg::entry_t [WAYS-1:0]    row_out,
    output logic [WAY_W-1:0]              victim
);

    logic                           dead_found;
    logic [WAY_W-1:0]               dead_idx;
    logic                           has3;
    logic                           has2;
    logic                           has1;
    logic [drp_pkg::RRPV_W-1:0]     top;
    logic [drp_pkg::RRPV_W-1:0]     add;
    logic [WAY_W-1:0]               top_idx;
    drp_pkg::entry_t [WAYS-1:0]     aged;

    // Lowest way with a zero dead counter
    always_comb
    begin
        dead_found = 1'b0;
        dead_idx   = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (row_in[i].dead == drp_pkg::DEAD_ZERO)
            begin
                dead_found = 1'b1;
                dead_idx   = WAY_W'(i);
            end
        end
    end

    // Highest rrpv in the set, and lowest way holding it
    always_comb
    begin
        has3 = 1'b0;
        has2 = 1'b0;
        has1 = 1'b0;
        for (int i = 0; i < WAYS; i++)
        begin
            has3 = has3 | (row_in[i].rrpv == 2'd3);
            has2 = has2 | (row_in[i].rrpv == 2'd2);
            has1 = has1 | (row_in[i].rrpv == 2'd1);
        end
        if (has3)
        begin
            top = 2'd3;
        end
        else if (has2)
        begin
            top = 2'd2;
        end
        else if (has1)
        begin
            top = 2'd1;
        end
        else
        begin
            top = 2'd0;
        end
        add = drp_pkg::RRPV_MAX - top;
        top_idx = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (row_in[i].rrpv == top)
            begin
                top_idx = WAY_W'(i);
            end
        end
        for (int i = 0; i < WAYS; i++)
        begin
            aged[i].rrpv = row_in[i].rrpv + add;
            aged[i].dead = row_in[i].dead;
        end
    end

    always_comb
    begin
        row_out = row_in;
        victim  = dead_found ? dead_idx : top_idx;
        if (cmd.sweep)
        begin
            for (int i = 0; i < WAYS; i++)
            begin
                if (row_in[i].dead != drp_pkg::DEAD_ZERO)
                begin
                    row_out[i].dead = row_in[i].dead - 2'd1;
                end
            end
        end
        else
        begin
            case (cmd.op)
                drp_pkg::OP_QUERY:
                begin
                    if (!dead_found)
                    begin
                        row_out = aged;
                    end
                end
                drp_pkg::OP_HIT:
                begin
                    if (row_in[way].dead != drp_pkg::DEAD_MAX)
                    begin
                        row_out[way].dead = row_in[way].dead + 2'd1;
                    end
                    row_out[way].rrpv = drp_pkg::RRPV_MRU;
                end
                drp_pkg::OP_FILL:
                begin
                    row_out[way].dead = drp_pkg::DEAD_FILL;
                    row_out[way].rrpv = cmd.ins_val;
                end
                default:
                begin
                    row_out = row_in;
                end
            endcase
        end
    end

endmodule

// ===== hdl/drp_duel.sv =====
// Set dueling: leader classification, policy selector training and bimodal
// insertion draw. Depends on drp_pkg.
`timescale 1ns / 1ps

module drp_duel #(
    parameter int SET_W = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        strobe,
    input  logic [drp_pkg::OP_W-1:0]    op,
    input  logic [SET_W-1:0]            set_idx,
    input  logic [drp_pkg::LEAD_W-1:0]  leader_sets,
    output logic [drp_pkg::RRPV_W-1:0]  ins_val
);

    localparam int CMP_W = (SET_W > drp_pkg::LEAD_W + 1) ? SET_W : drp_pkg::LEAD_W + 1;

    logic [drp_pkg::SEL_W-1:0]  sel_reg;
    logic [drp_pkg::SEL_W-1:0]  sel_next;
    logic [drp_pkg::LFSR_W-1:0] lfsr_reg;
    logic [drp_pkg::LFSR_W-1:0] lfsr_next;
    logic [drp_pkg::LFSR_W-1:0] lfsr_step;
    logic [CMP_W-1:0]           set_ext;
    logic                       static_leader;
    logic                       bimodal_leader;
    logic                       use_static;

    assign set_ext        = CMP_W'(set_idx);
    assign static_leader  = set_ext < CMP_W'(leader_sets);
    assign bimodal_leader = !static_leader && (set_ext < (CMP_W'(leader_sets) << 1));
    assign use_static     = static_leader ||
                            (!bimodal_leader && (sel_reg >= drp_pkg::SEL_RESET));
    assign lfsr_step      = drp_pkg::lfsr_next(lfsr_reg);

    always_comb
    begin
        if (use_static || (lfsr_step[drp_pkg::BIP_W-1:0] == '0))
        begin
            ins_val = drp_pkg::RRPV_STATIC;
        end
        else
        begin
            ins_val = drp_pkg::RRPV_DISTANT;
        end
    end

    always_comb
    begin
        sel_next  = sel_reg;
        lfsr_next = lfsr_reg;
        if (strobe && (op == drp_pkg::OP_HIT))
        begin
            if (static_leader && (sel_reg != drp_pkg::SEL_MAX))
            begin
                sel_next = sel_reg + 1'b1;
            end
            else if (bimodal_leader && (sel_reg != drp_pkg::SEL_MIN))
            begin
                sel_next = sel_reg - 1'b1;
            end
        end
        // Advance the draw only on a bimodal fill
        if (strobe && (op == drp_pkg::OP_FILL) && !use_static)
        begin
            lfsr_next = lfsr_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg  <= drp_pkg::SEL_RESET;
            lfsr_reg <= drp_pkg::LFSR_SEED;
        end
        else
        begin
            sel_reg  <= sel_next;
            lfsr_reg <= lfsr_next;
        end
    end

endmodule

// ===== hdl/drrip_dead_block_replacement_top.sv =====
// Top level of the dead-block aware DRRIP replacement unit: request sequencer,
// update/decay counter and configuration. Depends on drp_pkg, drp_row_mem,
// drp_row_logic and drp_duel.
`timescale 1ns / 1ps

// Usage
// - Request channel (in_valid/in_stall, opcode, set_index, way): opcode 0 asks
//   for a victim, 1 reports a hit on a way, 2 reports a fill of a way, 3 is
//   ignored. set_index and way are reduced modulo SETS and WAYS.
// - Result channel (out_valid/out_stall, victim_way): one transaction per
//   victim query, in request order. Updates produce no result.
// - Config port (cfg_write, cfg_index, cfg_data): index 0 decay_period,
//   index 1 leader_sets; write only while the unit is idle.
// Timing
// - Each request is read, then modified: the accept cycle reads the set row from the
//   row memory, and the modify state then modifies it and writes it back. The single
//   read-modify-write of the row memory sets the pace: no new request is taken
//   until the last one is written back. A victim is registered at that write-back.
// - After reset the row memory is cleared, with in_stall high throughout.
// - When an update completes a decay period, every row is swept to decrement its
//   nonzero dead counters, with in_stall high.
// - A stalled result is held in the output register; a following request is
//   still accepted, and a second query then waits until the result drains.

module drrip_dead_block_replacement_top #(
    parameter int SETS = 2048,
    parameter int WAYS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [drp_pkg::OP_W-1:0]          opcode,
    input  logic [drp_pkg::IDX_W-1:0]         set_index,
    input  logic [drp_pkg::WAY_IN_W-1:0]      way,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [drp_pkg::VICT_W-1:0]        victim_way,
    input  logic                              cfg_write,
    input  logic [drp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [drp_pkg::CFG_W-1:0]         cfg_data
);

    localparam int SET_W     = $clog2(SETS);
    localparam int CNT_W     = SET_W + 1;
    localparam int WAY_W     = $clog2(WAYS);
    localparam int ROW_W     = WAYS * drp_pkg::ENT_W;
    localparam int SET_STEPS = drp_pkg::mod_steps((1 << drp_pkg::IDX_W) - 1, SETS);
    localparam int WAY_STEPS = drp_pkg::mod_steps((1 << drp_pkg::WAY_IN_W) - 1, WAYS);

    localparam logic [ROW_W-1:0] RESET_ROW = {WAYS{drp_pkg::ENTRY_RESET}};

    // Sequencer states
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_MOD   = 2'd2;
    localparam logic [1:0] ST_SWEEP = 2'd3;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_next;
    logic [drp_pkg::OP_W-1:0]    op_reg;
    logic [drp_pkg::OP_W-1:0]    op_next;
    logic [SET_W-1:0]            set_reg;
    logic [SET_W-1:0]            set_next;
    logic [WAY_W-1:0]            way_reg;
    logic [WAY_W-1:0]            way_next;
    logic [drp_pkg::DECAY_W-1:0] upd_cnt_reg;
    logic [drp_pkg::DECAY_W-1:0] upd_cnt_next;
    logic [drp_pkg::DECAY_W-1:0] upd_cnt_inc;
    logic [drp_pkg::DECAY_W-1:0] decay_period_reg;
    logic [drp_pkg::LEAD_W-1:0]  leader_sets_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [drp_pkg::VICT_W-1:0]  victim_way_reg;
    logic [drp_pkg::VICT_W-1:0]  victim_way_next;

    logic [drp_pkg::IDX_W-1:0]    set_rem;
    logic [drp_pkg::WAY_IN_W-1:0] way_rem;
    logic [SET_W-1:0]             set_mod;
    logic [WAY_W-1:0]             way_mod;

    logic                 mem_we;
    logic [SET_W-1:0]     mem_waddr;
    logic [ROW_W-1:0]     mem_wdata;
    logic                 mem_re;
    logic [SET_W-1:0]     mem_raddr;
    logic [ROW_W-1:0]     mem_rdata;

    drp_pkg::row_cmd_t             row_cmd;
    logic [ROW_W-1:0]              row_out;
    logic [WAY_W-1:0]              row_victim;
    logic [drp_pkg::RRPV_W-1:0]    ins_val;
    logic                          duel_strobe;

    // Reduce set and way modulo the geometry: restoring compare/subtract
    always_comb
    begin
        set_rem = set_index;
        for (int k = SET_STEPS - 1; k >= 0; k--)
        begin
            if ({1'b0, set_rem} >= (drp_pkg::IDX_W + 1)'(SETS << k))
            begin
                set_rem = set_rem - drp_pkg::IDX_W'(SETS << k);
            end
        end
        way_rem = way;
        for (int k = WAY_STEPS - 1; k >= 0; k--)
        begin
            if ({1'b0, way_rem} >= (drp_pkg::WAY_IN_W + 1)'(WAYS << k))
            begin
                way_rem = way_rem - drp_pkg::WAY_IN_W'(WAYS << k);
            end
        end
    end

    assign set_mod = SET_W'(set_rem);
    assign way_mod = WAY_W'(way_rem);

    drp_row_mem #(
        .DEPTH  (SETS),
        .ADDR_W (SET_W),
        .WIDTH  (ROW_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign row_cmd.op      = op_reg;
    assign row_cmd.sweep   = (state_reg == ST_SWEEP);
    assign row_cmd.ins_val = ins_val;

    drp_row_logic #(
        .WAYS  (WAYS),
        .WAY_W (WAY_W)
    ) u_row (
        .cmd     (row_cmd),
        .way     (way_reg),
        .row_in  (mem_rdata),
        .row_out (row_out),
        .victim  (row_victim)
    );

    drp_duel #(
        .SET_W (SET_W)
    ) u_duel (
        .clk         (clk),
        .rst_n       (rst_n),
        .strobe      (duel_strobe),
        .op          (op_reg),
        .set_idx     (set_reg),
        .leader_sets (leader_sets_reg),
        .ins_val     (ins_val)
    );

    assign upd_cnt_inc = upd_cnt_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        set_next        = set_reg;
        way_next        = way_reg;
        upd_cnt_next    = upd_cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        victim_way_next = victim_way_reg;
        mem_we          = 1'b0;
        mem_waddr       = set_reg;
        mem_wdata       = row_out;
        mem_re          = 1'b0;
        mem_raddr       = set_mod;
        duel_strobe     = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Write the reset row, one set per cycle
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[SET_W-1:0];
                mem_wdata = RESET_ROW;
                if (cnt_reg == CNT_W'(SETS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mem_re     = 1'b1;
                    op_next    = opcode;
                    set_next   = set_mod;
                    way_next   = way_mod;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                // Hold a query while the previous result still waits
                if (!((op_reg == drp_pkg::OP_QUERY) && out_valid_reg && out_stall))
                begin
                    mem_we     = 1'b1;
                    state_next = ST_IDLE;
                    if (op_reg == drp_pkg::OP_QUERY)
                    begin
                        out_valid_next  = 1'b1;
                        victim_way_next = drp_pkg::VICT_W'(row_victim);
                    end
                    if ((op_reg == drp_pkg::OP_HIT) || (op_reg == drp_pkg::OP_FILL))
                    begin
                        duel_strobe = 1'b1;
                        if (upd_cnt_inc >= decay_period_reg)
                        begin
                            upd_cnt_next = '0;
                            cnt_next     = '0;
                            state_next   = ST_SWEEP;
                        end
                        else
                        begin
                            upd_cnt_next = upd_cnt_inc;
                        end
                    end
                end
            end
            ST_SWEEP:
            begin
                // Read row cnt, write back decayed row cnt-1
                mem_raddr = cnt_reg[SET_W-1:0];
                mem_waddr = SET_W'(cnt_reg - 1'b1);
                if (cnt_reg != CNT_W'(SETS))
                begin
                    mem_re = 1'b1;
                end
                if (cnt_reg != '0)
                begin
                    mem_we = 1'b1;
                end
                if (cnt_reg == CNT_W'(SETS))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            op_reg        <= drp_pkg::OP_NONE;
            upd_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            upd_cnt_reg   <= upd_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        set_reg        <= set_next;
        way_reg        <= way_next;
        victim_way_reg <= victim_way_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_period_reg <= drp_pkg::DECAY_RESET;
            leader_sets_reg  <= drp_pkg::LEAD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                drp_pkg::CFG_DECAY:
                begin
                    decay_period_reg <= cfg_data;
                end
                drp_pkg::CFG_LEADER:
                begin
                    leader_sets_reg <= cfg_data[drp_pkg::LEAD_W-1:0];
                end
            endcase
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign victim_way = victim_way_reg;

endmodule

// ===== tb/sv/drrip_dead_block_replacement_top_tb.sv =====
// Self-checking testbench for the dead-block aware DRRIP replacement unit.
// Depends on drp_pkg and drrip_dead_block_replacement_top; carries its own line-state predictor.
`timescale 1ns / 1ps

module drrip_dead_block_replacement_top_tb;

    import drp_pkg::*;

    localparam int SETS        = 2048;
    localparam int WAYS        = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int POOL_N      = 6;
    localparam int N_PHASES    = 5;
    localparam int CALM_TAIL   = 150;

    // One row of the directed table; typed rows carry a victim read off by hand
    typedef struct {
        logic [OP_W-1:0]     op;
        logic [IDX_W-1:0]    set_idx;
        logic [WAY_IN_W-1:0] way_sel;
        bit                  typed;
        logic [VICT_W-1:0]   victim;
    } probe_t;

    // One random phase: register settings, transaction count, hit bias
    typedef struct {
        bit                 write_regs;
        logic [DECAY_W-1:0] decay;
        logic [LEAD_W-1:0]  leaders;
        int                 n_items;
        bit                 drain_sel;
    } phase_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       opcode = OP_NONE;
    logic [IDX_W-1:0]      set_index = '0;
    logic [WAY_IN_W-1:0]   way = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [VICT_W-1:0]     victim_way;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_DECAY;
    logic [CFG_W-1:0]      cfg_data = '0;

    // Predicted line state and control state
    logic [RRPV_W-1:0]  rrpv_m [SETS][WAYS];
    logic [DEAD_W-1:0]  dead_m [SETS][WAYS];
    logic [SEL_W-1:0]   selector_m;
    logic [DECAY_W-1:0] updates_m;
    logic [LFSR_W-1:0]  lfsr_m;
    logic [DECAY_W-1:0] decay_m;
    int                 leads_m;

    logic [VICT_W-1:0]  victims_due [$];
    logic [VICT_W-1:0]  last_victim;
    logic [VICT_W-1:0]  exp_victim;
    int                 errors = 0;
    int                 cycles = 0;
    int                 stall_left = 0;
    bit                 calm = 1'b0;

    drrip_dead_block_replacement_top #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .set_index  (set_index),
        .way        (way),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .victim_way (victim_way),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the predicted state by one request; return the victim for a query.
    task automatic apply_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] s_in,
                                 input logic [WAY_IN_W-1:0] w_in, output bit has_victim,
                                 output logic [VICT_W-1:0] vw);
        int                s;
        int                w;
        int                i;
        int                j;
        bit                st_lead;
        bit                bi_lead;
        bit                use_static;
        bit                found;
        logic [RRPV_W-1:0] top;
        logic [RRPV_W-1:0] ins;
        s = int'(s_in) % SETS;
        w = int'(w_in) % WAYS;
        st_lead = s < leads_m;
        bi_lead = !st_lead && (s < 2 * leads_m);
        has_victim = 1'b0;
        vw = '0;
        if (op == OP_QUERY)
        begin
            has_victim = 1'b1;
            found = 1'b0;
            // A predicted-dead line goes first
            for (i = 0; i < WAYS; i++)
            begin
                if (!found && dead_m[s][i] == DEAD_ZERO)
                begin
                    vw = VICT_W'(i);
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                // Age the whole set until some line reaches the distant value
                top = RRPV_MRU;
                for (i = 0; i < WAYS; i++)
                begin
                    if (rrpv_m[s][i] > top)
                        top = rrpv_m[s][i];
                end
                for (i = 0; i < WAYS; i++)
                begin
                    rrpv_m[s][i] = rrpv_m[s][i] + (RRPV_MAX - top);
                end
                for (i = 0; i < WAYS; i++)
                begin
                    if (!found && rrpv_m[s][i] == RRPV_MAX)
                    begin
                        vw = VICT_W'(i);
                        found = 1'b1;
                    end
                end
            end
        end
        else if (op == OP_HIT || op == OP_FILL)
        begin
            if (op == OP_HIT)
            begin
                if (dead_m[s][w] < DEAD_MAX)
                    dead_m[s][w] = dead_m[s][w] + 1'b1;
                rrpv_m[s][w] = RRPV_MRU;
                if (st_lead)
                begin
                    if (selector_m < SEL_MAX)
                        selector_m = selector_m + 1'b1;
                end
                else if (bi_lead)
                begin
                    if (selector_m > SEL_MIN)
                        selector_m = selector_m - 1'b1;
                end
            end
            else
            begin
                dead_m[s][w] = DEAD_FILL;
                if (st_lead)
                    use_static = 1'b1;
                else if (bi_lead)
                    use_static = 1'b0;
                else
                    use_static = selector_m >= SEL_RESET;
                ins = RRPV_STATIC;
                if (!use_static)
                begin
                    lfsr_m = (lfsr_m >> 1) ^ (lfsr_m[0] ? LFSR_TAPS : '0);
                    ins = (lfsr_m[BIP_W-1:0] == '0) ? RRPV_STATIC : RRPV_DISTANT;
                end
                rrpv_m[s][w] = ins;
            end
            updates_m = updates_m + 1'b1;
            if (updates_m >= decay_m)
            begin
                updates_m = '0;
                for (i = 0; i < SETS; i++)
                begin
                    for (j = 0; j < WAYS; j++)
                    begin
                        if (dead_m[i][j] > DEAD_ZERO)
                            dead_m[i][j] = dead_m[i][j] - 1'b1;
                    end
                end
            end
        end
    endtask

    // Present one transaction after an optional gap, hold it until accepted,
    // then predict it at the accepting edge.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] s,
                                input logic [WAY_IN_W-1:0] w, input bit typed,
                                input logic [VICT_W-1:0] typed_victim);
        bit                has_victim;
        logic [VICT_W-1:0] vw;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        set_index <= s;
        way       <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_request(op, s, w, has_victim, vw);
        if (has_victim)
        begin
            last_victim = vw;
            victims_due.push_back(typed ? typed_victim : vw);
        end
    endtask

    // Pick a set of the given class under the current leader count:
    // 0 static leader, 1 bimodal leader, 2 follower. Fall back to any set.
    function automatic logic [IDX_W-1:0] draw_set(input int kind);
        int lo;
        int hi;
        case (kind)
            0:
            begin
                lo = 0;
                hi = leads_m - 1;
            end
            1:
            begin
                lo = leads_m;
                hi = 2 * leads_m - 1;
            end
            default:
            begin
                lo = 2 * leads_m;
                hi = SETS - 1;
            end
        endcase
        if (hi > SETS - 1)
            hi = SETS - 1;
        if (hi < lo)
            return IDX_W'($urandom_range(0, SETS - 1));
        return IDX_W'($urandom_range(lo, hi));
    endfunction

    // Result side: check every accepted transaction against the oldest
    // prediction, and stall in random bursts except in the calm tail.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (victims_due.size() == 0)
            begin
                $display("%0t: unexpected victim transaction, actual %0d", $time, victim_way);
                errors++;
            end
            else
            begin
                exp_victim = victims_due.pop_front();
                if (victim_way !== exp_victim)
                begin
                    $display("%0t: victim_way mismatch, expected %0d, actual %0d",
                             $time, exp_victim, victim_way);
                    errors++;
                end
            end
        end
        if (calm)
            stall_left = 0;
        else if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 12);
        out_stall <= (stall_left > 0);
    end

    // Watchdog: fail the run once the cycle counter reaches CYCLE_LIMIT
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        probe_t            plan [24];
        phase_t            phases [N_PHASES];
        logic [IDX_W-1:0]  pool [POOL_N];
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  s;
        logic [WAY_IN_W-1:0] w;
        logic [IDX_W-1:0]  pend_set;
        logic [WAY_IN_W-1:0] pend_way;
        bit                pend;
        int                r;
        int                i;
        int                j;
        int                p;
        int                count;

        // Predicted state after reset
        for (i = 0; i < SETS; i++)
        begin
            for (j = 0; j < WAYS; j++)
            begin
                rrpv_m[i][j] = RRPV_MAX;
                dead_m[i][j] = DEAD_ZERO;
            end
        end
        selector_m = SEL_RESET;
        updates_m  = '0;
        lfsr_m     = LFSR_SEED;
        decay_m    = DECAY_RESET;
        leads_m    = int'(LEAD_RESET);

        // Directed table. After reset every line is dead, so a query picks way 0.
        plan[0] = '{OP_QUERY, 11'd0, 4'd0, 1'b1, 4'd0};
        // Unused opcode: no result, no state change
        plan[1] = '{OP_NONE, 11'd2047, 4'd15, 1'b0, 4'd0};
        // Fill every way of the top follower set: all dead counters at 1, static
        // insertion at 2
        for (i = 0; i < WAYS; i++)
            plan[2 + i] = '{OP_FILL, 11'd2047, WAY_IN_W'(i), 1'b0, 4'd0};
        // No dead line left: age the set by one, all reach 3, lowest way wins
        plan[18] = '{OP_QUERY, 11'd2047, 4'd0, 1'b1, 4'd0};
        plan[19] = '{OP_HIT, 11'd2047, 4'd0, 1'b0, 4'd0};
        // Way 0 is now most recent, way 1 is the first at 3
        plan[20] = '{OP_QUERY, 11'd2047, 4'd0, 1'b1, 4'd1};
        // Hit in a static leader trains the selector upward
        plan[21] = '{OP_HIT, 11'd0, 4'd15, 1'b0, 4'd0};
        plan[22] = '{OP_QUERY, 11'd0, 4'd0, 1'b1, 4'd0};
        plan[23] = '{OP_FILL, 11'd1024, 4'd15, 1'b0, 4'd0};

        // Phases: reset settings, then largest period with all sets leaders while
        // hits drive the selector to its floor, then a short period, then decay
        // on every update with no leaders, then a mid setting.
        phases[0] = '{1'b0, DECAY_RESET, LEAD_RESET, 170, 1'b0};
        phases[1] = '{1'b1, 32'hFFFF_FFFF, 11'd1024, 700, 1'b1};
        phases[2] = '{1'b1, 32'd37, 11'd3, 250, 1'b0};
        phases[3] = '{1'b1, 32'd1, 11'd0, 40, 1'b0};
        phases[4] = '{1'b1, 32'd500, 11'd1000, 180, 1'b0};

        // Hold reset, then release it once
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < 24; i++)
            send_request(plan[i].op, plan[i].set_idx, plan[i].way_sel, plan[i].typed,
                         plan[i].victim);

        pend = 1'b0;
        for (p = 0; p < N_PHASES; p++)
        begin
            // Drain all victims and let any decay sweep finish before touching
            // the registers.
            in_valid <= 1'b0;
            while (victims_due.size() != 0)
                @(posedge clk);
            repeat (SETS + 8) @(posedge clk);
            if (phases[p].write_regs)
            begin
                cfg_write <= 1'b1;
                cfg_index <= CFG_DECAY;
                cfg_data  <= phases[p].decay;
                @(posedge clk);
                cfg_index <= CFG_LEADER;
                cfg_data  <= CFG_W'(phases[p].leaders);
                @(posedge clk);
                cfg_write <= 1'b0;
                decay_m = phases[p].decay;
                leads_m = int'(phases[p].leaders);
            end

            // Concentrate each phase on a few sets so that they fill up and
            // reach the aging path.
            for (i = 0; i < POOL_N; i++)
                pool[i] = phases[p].drain_sel ? draw_set(1) : draw_set(i % 3);
            pend = 1'b0;

            count = 0;
            while (count < phases[p].n_items)
            begin
                if (p == N_PHASES - 1 && phases[p].n_items - count <= CALM_TAIL)
                    calm = 1'b1;
                if (pend && $urandom_range(0, 9) != 0)
                begin
                    // Well-formed miss: fill the way the last query picked
                    op = OP_FILL;
                    s  = pend_set;
                    w  = pend_way;
                end
                else
                begin
                    s = pool[$urandom_range(0, POOL_N - 1)];
                    w = WAY_IN_W'($urandom_range(0, WAYS - 1));
                    if (phases[p].drain_sel && $urandom_range(0, 99) < 85)
                        op = OP_HIT;
                    else
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 25)
                            op = OP_QUERY;
                        else if (r < 55)
                            op = OP_HIT;
                        else if (r < 75)
                            op = OP_FILL;
                        else if (r < 82)
                            op = OP_NONE;
                        else
                        begin
                            // Noise: any opcode on any set
                            op = OP_W'($urandom_range(0, 3));
                            s  = IDX_W'($urandom_range(0, SETS - 1));
                        end
                    end
                end
                pend = 1'b0;
                send_request(op, s, w, 1'b0, '0);
                if (op == OP_QUERY)
                begin
                    pend     = 1'b1;
                    pend_set = s;
                    pend_way = last_victim;
                end
                if (op != OP_NONE)
                    count++;
            end
        end

        // Drop valid, drain, and let a final sweep run out
        in_valid <= 1'b0;
        while (victims_due.size() != 0)
            @(posedge clk);
        repeat (SETS + 8) @(posedge clk);
        if (errors == 0 && victims_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
